@@ hdl/rpgt_pkg.sv @@
// ----------------------------------------------------------------------------
// rpgt_pkg
// Shared types and constants for the range point gate and transform block:
// beat payloads, configuration indexes, status codes and stage bundles.
// ----------------------------------------------------------------------------
package rpgt_pkg;

	// input beat: one range-map point, Q20.12
	typedef struct packed {
		logic signed [31:0] point_x;
		logic signed [31:0] point_y;
		logic signed [31:0] point_z;
	} rpgt_in_t;

	// output beat: camera point, squared range Q39.24 and status
	typedef struct packed {
		logic signed [31:0] cam_x;
		logic signed [31:0] cam_y;
		logic signed [31:0] cam_z;
		logic        [62:0] range_sq;
		logic        [2:0]  status;
	} rpgt_out_t;

	// status codes
	localparam logic [2:0] ST_VALID    = 3'd0;
	localparam logic [2:0] ST_SENTINEL = 3'd1;
	localparam logic [2:0] ST_ZERO     = 3'd2;
	localparam logic [2:0] ST_RANGE    = 3'd3;
	localparam logic [2:0] ST_BEHIND   = 3'd4;

	// configuration register indexes
	localparam int unsigned CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_ROT_X     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ROT_Y     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ROT_Z     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_OFF_X     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_OFF_Y     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_OFF_Z     = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_RANGE_LO  = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_RANGE_HI  = 3'd7;
	localparam int unsigned CFG_DATA_W = 63;

	// reset values
	localparam logic [47:0] ROT_X_RST = 48'h4000_0000_0000;
	localparam logic [47:0] ROT_Y_RST = 48'h0000_4000_0000;
	localparam logic [47:0] ROT_Z_RST = 48'h0000_0000_4000;
	localparam logic [62:0] RANGE_MAX = {63{1'b1}};

	// no-data sentinel, -90000.0 in Q20.12
	localparam logic signed [31:0] SENTINEL_Q12 = -32'sd368640000;

	localparam logic signed [31:0] CAM_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] CAM_MIN = 32'sh8000_0000;

	// transform coefficients and offsets, index 0 is X
	typedef struct packed {
		logic [2:0][47:0] rot;
		logic [2:0][31:0] off;
	} rpgt_xf_cfg_t;

	// transformed beat handed from transform to range stages
	typedef struct packed {
		logic               valid;
		logic [2:0]         early;
		rpgt_in_t           pt;
		logic signed [31:0] cam_x;
		logic signed [31:0] cam_y;
		logic signed [31:0] cam_z;
	} rpgt_xf_t;

endpackage

@@ hdl/rpgt_xform.sv @@
// ----------------------------------------------------------------------------
// rpgt_xform
// Early classification and affine transform: capture, nine products,
// rounded row sums, offset add with saturation. Four register stages.
// ----------------------------------------------------------------------------
module rpgt_xform import rpgt_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         adv,
	input  logic         in_valid,
	input  rpgt_in_t     in_data,
	input  rpgt_xf_cfg_t cfg,
	output rpgt_xf_t     xf
);

	logic               valid_s1, valid_s2, valid_s3, valid_s4;
	logic [2:0]         early_s1, early_s2, early_s3, early_s4;
	rpgt_in_t           pt_s1, pt_s2, pt_s3, pt_s4;
	logic signed [47:0] prod_s2 [3][3];
	logic signed [35:0] sum_s3 [3];
	logic signed [31:0] cam_s4 [3];

	logic [2:0]         early_c;
	logic signed [31:0] p_c [3];
	logic signed [49:0] acc_c [3];
	logic signed [36:0] off_c [3];

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	// sentinel and all-zero classification
	always_comb begin
		if (in_data.point_x < SENTINEL_Q12) begin
			early_c = ST_SENTINEL;
		end else if (in_data.point_x == 32'sd0 && in_data.point_y == 32'sd0
				&& in_data.point_z == 32'sd0) begin
			early_c = ST_ZERO;
		end else begin
			early_c = ST_VALID;
		end
	end

	assign p_c[0] = pt_s1.point_x;
	assign p_c[1] = pt_s1.point_y;
	assign p_c[2] = pt_s1.point_z;

	// rounded row sums, halves go up
	always_comb begin
		for (int r = 0; r < 3; r++) begin
			acc_c[r] = 50'(prod_s2[r][0]) + 50'(prod_s2[r][1]) + 50'(prod_s2[r][2])
				+ 50'sd8192;
		end
	end

	// offset add with saturation
	always_comb begin
		for (int r = 0; r < 3; r++) begin
			off_c[r] = 37'(sum_s3[r]) + 37'($signed(cfg.off[r]));
		end
	end

	// payload stages
	always_ff @(posedge clk) begin
		if (adv) begin
			early_s1 <= early_c;
			pt_s1    <= in_data;
			early_s2 <= early_s1;
			pt_s2    <= pt_s1;
			early_s3 <= early_s2;
			pt_s3    <= pt_s2;
			early_s4 <= early_s3;
			pt_s4    <= pt_s3;
			for (int r = 0; r < 3; r++) begin
				for (int k = 0; k < 3; k++) begin
					prod_s2[r][k] <= $signed(cfg.rot[r][47-16*k -: 16]) * p_c[k];
				end
				sum_s3[r] <= acc_c[r][49:14];
				if (off_c[r][36:31] != {6{off_c[r][31]}}) begin
					cam_s4[r] <= off_c[r][36] ? CAM_MIN : CAM_MAX;
				end else begin
					cam_s4[r] <= off_c[r][31:0];
				end
			end
		end
	end

	assign xf.valid = valid_s4;
	assign xf.early = early_s4;
	assign xf.pt    = pt_s4;
	assign xf.cam_x = cam_s4[0];
	assign xf.cam_y = cam_s4[1];
	assign xf.cam_z = cam_s4[2];

endmodule

@@ hdl/rpgt_range.sv @@
// ----------------------------------------------------------------------------
// rpgt_range
// Squared range and gating: squares, saturated sum, limit and front tests,
// output register. Three register stages.
// ----------------------------------------------------------------------------
module rpgt_range import rpgt_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        adv,
	input  rpgt_xf_t    xf,
	input  logic [62:0] lim_lo,
	input  logic [62:0] lim_hi,
	output logic        out_valid,
	output rpgt_out_t   out_data
);

	logic               valid_s5, valid_s6, out_valid_q;
	rpgt_xf_t           xf_s5, xf_s6;
	logic        [63:0] sq_s5 [3];
	logic        [62:0] range_s6;
	rpgt_out_t          out_q;

	logic signed [31:0] c_c [3];
	logic signed [63:0] sq_c [3];
	logic        [63:0] tot_c;
	rpgt_out_t          res_c;

	assign c_c[0] = xf.cam_x;
	assign c_c[1] = xf.cam_y;
	assign c_c[2] = xf.cam_z;

	// squares of the saturated coordinates
	always_comb begin
		for (int r = 0; r < 3; r++) begin
			sq_c[r] = c_c[r] * c_c[r];
		end
	end

	// sum of squares, fits in 64 bits
	assign tot_c = sq_s5[0] + sq_s5[1] + sq_s5[2];

	// status and pass-through selection
	always_comb begin
		res_c.range_sq = range_s6;
		if (xf_s6.early != ST_VALID) begin
			res_c.status   = xf_s6.early;
			res_c.range_sq = '0;
		end else if (range_s6 < lim_lo || range_s6 > lim_hi) begin
			res_c.status = ST_RANGE;
		end else if (xf_s6.cam_x <= 32'sd0) begin
			res_c.status = ST_BEHIND;
		end else begin
			res_c.status = ST_VALID;
		end
		if (res_c.status == ST_VALID) begin
			res_c.cam_x = xf_s6.cam_x;
			res_c.cam_y = xf_s6.cam_y;
			res_c.cam_z = xf_s6.cam_z;
		end else begin
			res_c.cam_x = xf_s6.pt.point_x;
			res_c.cam_y = xf_s6.pt.point_y;
			res_c.cam_z = xf_s6.pt.point_z;
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5    <= 1'b0;
			valid_s6    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			valid_s5    <= xf.valid;
			valid_s6    <= valid_s5;
			out_valid_q <= valid_s6;
		end
	end

	// payload stages
	always_ff @(posedge clk) begin
		if (adv) begin
			xf_s5 <= xf;
			xf_s6 <= xf_s5;
			for (int r = 0; r < 3; r++) begin
				sq_s5[r] <= sq_c[r];
			end
			range_s6 <= tot_c[63] ? RANGE_MAX : tot_c[62:0];
			out_q    <= res_c;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

@@ hdl/range_point_gate_transform.sv @@
// ----------------------------------------------------------------------------
// range_point_gate_transform
// Gates range-map points and moves them into the camera frame.
//
// Input channel in_valid/in_stall/in_data carries one point (Q20.12) a beat.
// Output channel out_valid/out_stall/out_data carries one result a beat:
// camera point (or the input point when rejected), squared range and status.
// Configuration is a plain write port (cfg_we, cfg_index, cfg_data) and must
// only be written while no beat is in flight.
// Pipeline: seven register stages, from the capture register to the output register.
// Throughput: one beat per cycle while the output is not stalled; the nine
// transform products and three squares each have their own multiplier.
// A stalled output beat freezes the whole pipeline, so in_stall is high
// exactly while a valid output beat is stalled; nothing is lost or repeated.
// Reset clears all valid bits and loads the identity rotation, zero offsets
// and the widest range limits.
// ----------------------------------------------------------------------------
module range_point_gate_transform import rpgt_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  rpgt_in_t              in_data,
	output logic                  out_valid,
	input  logic                  out_stall,
	output rpgt_out_t             out_data,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	logic [2:0][47:0] rot_q;
	logic [2:0][31:0] off_q;
	logic [62:0]      lim_lo_q;
	logic [62:0]      lim_hi_q;

	logic             adv;
	rpgt_xf_cfg_t     xf_cfg;
	rpgt_xf_t         xf;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rot_q[0] <= ROT_X_RST;
			rot_q[1] <= ROT_Y_RST;
			rot_q[2] <= ROT_Z_RST;
			off_q    <= '0;
			lim_lo_q <= '0;
			lim_hi_q <= RANGE_MAX;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_ROT_X:    rot_q[0] <= cfg_data[47:0];
				CFG_ROT_Y:    rot_q[1] <= cfg_data[47:0];
				CFG_ROT_Z:    rot_q[2] <= cfg_data[47:0];
				CFG_OFF_X:    off_q[0] <= cfg_data[31:0];
				CFG_OFF_Y:    off_q[1] <= cfg_data[31:0];
				CFG_OFF_Z:    off_q[2] <= cfg_data[31:0];
				CFG_RANGE_LO: lim_lo_q <= cfg_data[62:0];
				CFG_RANGE_HI: lim_hi_q <= cfg_data[62:0];
				default: ;
			endcase
		end
	end

	// pipeline moves whenever the output register can take a beat
	assign adv      = !out_valid || !out_stall;
	assign in_stall = !adv;

	assign xf_cfg.rot = rot_q;
	assign xf_cfg.off = off_q;

	rpgt_xform u_xform (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_valid (in_valid),
		.in_data  (in_data),
		.cfg      (xf_cfg),
		.xf       (xf)
	);

	rpgt_range u_range (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.xf        (xf),
		.lim_lo    (lim_lo_q),
		.lim_hi    (lim_hi_q),
		.out_valid (out_valid),
		.out_data  (out_data)
	);

	// a passing point lies in front and within the limits
	a_valid_gated: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status == ST_VALID |->
			out_data.cam_x > 32'sd0 && out_data.range_sq >= lim_lo_q
			&& out_data.range_sq <= lim_hi_q)
		else $error("passing point violates gate");

	// early rejects carry no range
	a_early_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.status == ST_SENTINEL || out_data.status == ST_ZERO)
			|-> out_data.range_sq == '0)
		else $error("early reject with non-zero range");

	// sentinel beats pass the input coordinate through
	a_sentinel_pass: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status == ST_SENTINEL |-> out_data.cam_x < SENTINEL_Q12)
		else $error("sentinel beat without sentinel coordinate");

endmodule
